@@ rtl/bst_pkg.sv @@
package bst_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned NUM_W  = 31;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned KIND_W = 3;

    localparam logic [KIND_W-1:0] KIND_CHAR   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_STRING = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NUMBER = 3'd2;
    localparam logic [KIND_W-1:0] KIND_IDENT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SYMBOL = 3'd4;
    localparam logic [KIND_W-1:0] KIND_END    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd6;

    localparam logic ERR_NEWLINE_IN_STRING = 1'b0;
    localparam logic ERR_EOF_IN_STRING     = 1'b1;

    localparam logic [CHAR_W-1:0] CH_NEWLINE    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_QUOTE      = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SLASH      = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE       = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z    = 8'h7A;

    localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] char_code;
        logic [NUM_W-1:0]  number_value;
        logic [CNT_W-1:0]  line_number;
        logic [CNT_W-1:0]  column_number;
        logic              error_code;
        logic              last;
    } result_t;

    // Up to two result words produced by one input word.
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

    function automatic result_t make_res(
        input logic [KIND_W-1:0] kind,
        input logic [CHAR_W-1:0] ch,
        input logic [NUM_W-1:0]  num,
        input logic [CNT_W-1:0]  line,
        input logic [CNT_W-1:0]  col,
        input logic              err
    );
        result_t r;
        r.kind          = kind;
        r.char_code     = ch;
        r.number_value  = num;
        r.line_number   = line;
        r.column_number = col;
        r.error_code    = err;
        r.last          = 1'b0;
        return r;
    endfunction

endpackage

@@ rtl/bst_lexer.sv @@
module bst_lexer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fire,
    input  logic [bst_pkg::CHAR_W-1:0] byte_in,
    input  logic                      end_of_file,
    output bst_pkg::push_t            push
);

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_SLASH   = 3'd1,
        MODE_COMMENT = 3'd2,
        MODE_STRING  = 3'd3,
        MODE_NUMBER  = 3'd4,
        MODE_IDENT   = 3'd5,
        MODE_ERROR   = 3'd6
    } mode_t;

    localparam int unsigned PROD_W = bst_pkg::NUM_W + 4;

    mode_t                       mode_reg, mode_next;
    logic [bst_pkg::CNT_W-1:0]   line_reg, line_next;
    logic [bst_pkg::CNT_W-1:0]   col_reg, col_next;
    logic [bst_pkg::CNT_W-1:0]   tsc_reg, tsc_next;
    logic [bst_pkg::NUM_W-1:0]   acc_reg, acc_next;

    logic [bst_pkg::CNT_W-1:0]   col_inc;
    logic [bst_pkg::CNT_W-1:0]   line_inc;
    logic                        is_digit;
    logic                        is_letter;
    logic [3:0]                  digit_val;
    logic [PROD_W-1:0]           acc_prod;
    logic [PROD_W-1:0]           acc_sum;
    logic [bst_pkg::NUM_W-1:0]   acc_sat;
    logic                        close_v;
    logic                        sec_v;
    logic                        do_idle;
    bst_pkg::result_t            close_r;
    bst_pkg::result_t            sec_r;
    bst_pkg::result_t            blank_r;

    function automatic logic [bst_pkg::CNT_W-1:0] sat_inc(input logic [bst_pkg::CNT_W-1:0] v);
        return (v == bst_pkg::CNT_MAX) ? v : v + bst_pkg::CNT_W'(1);
    endfunction

    assign col_inc   = sat_inc(col_reg);
    assign line_inc  = sat_inc(line_reg);
    assign is_digit  = (byte_in >= bst_pkg::CH_ZERO) && (byte_in <= bst_pkg::CH_NINE);
    assign is_letter = ((byte_in >= bst_pkg::CH_UPPER_A) && (byte_in <= bst_pkg::CH_UPPER_Z))
                    || ((byte_in >= bst_pkg::CH_LOWER_A) && (byte_in <= bst_pkg::CH_LOWER_Z));
    assign digit_val = 4'(byte_in - bst_pkg::CH_ZERO);

    // Times ten as two shifted adds, then saturate.
    assign acc_prod = PROD_W'({acc_reg, 3'b000}) + PROD_W'({acc_reg, 1'b0});
    assign acc_sum  = acc_prod + PROD_W'(digit_val);
    assign acc_sat  = (acc_sum > PROD_W'(bst_pkg::NUM_MAX)) ? bst_pkg::NUM_MAX
                                                             : acc_sum[bst_pkg::NUM_W-1:0];

    always_comb
    begin
        mode_next = mode_reg;
        line_next = line_reg;
        col_next  = col_reg;
        tsc_next  = tsc_reg;
        acc_next  = acc_reg;
        blank_r   = bst_pkg::make_res(bst_pkg::KIND_CHAR, '0, '0, '0, '0, 1'b0);
        close_v   = 1'b0;
        close_r   = blank_r;
        sec_v     = 1'b0;
        sec_r     = blank_r;
        do_idle   = 1'b0;

        if (end_of_file)
        begin
            close_v = 1'b1;
            unique case (mode_reg)
                MODE_SLASH:
                    close_r = bst_pkg::make_res(bst_pkg::KIND_SYMBOL, bst_pkg::CH_SLASH, '0,
                                                line_reg, tsc_reg, 1'b0);
                MODE_NUMBER:
                    close_r = bst_pkg::make_res(bst_pkg::KIND_NUMBER, '0, acc_reg,
                                                line_reg, tsc_reg, 1'b0);
                MODE_IDENT:
                    close_r = bst_pkg::make_res(bst_pkg::KIND_IDENT, '0, '0,
                                                line_reg, tsc_reg, 1'b0);
                MODE_STRING:
                    close_r = bst_pkg::make_res(bst_pkg::KIND_ERROR, '0, '0, line_reg, tsc_reg,
                                                bst_pkg::ERR_EOF_IN_STRING);
                default:
                    close_v = 1'b0;
            endcase
            sec_v     = 1'b1;
            sec_r     = bst_pkg::make_res(bst_pkg::KIND_END, '0, '0, line_reg, col_inc, 1'b0);
            mode_next = MODE_IDLE;
            line_next = bst_pkg::CNT_W'(1);
            col_next  = '0;
            tsc_next  = '0;
            acc_next  = '0;
        end
        else if (mode_reg != MODE_ERROR)
        begin
            col_next = col_inc;
            unique case (mode_reg)
                MODE_SLASH:
                begin
                    if (byte_in == bst_pkg::CH_SLASH)
                    begin
                        mode_next = MODE_COMMENT;
                    end
                    else
                    begin
                        close_v = 1'b1;
                        close_r = bst_pkg::make_res(bst_pkg::KIND_SYMBOL, bst_pkg::CH_SLASH,
                                                    '0, line_reg, tsc_reg, 1'b0);
                        do_idle = 1'b1;
                    end
                end
                MODE_COMMENT:
                begin
                    if (byte_in == bst_pkg::CH_NEWLINE)
                    begin
                        line_next = line_inc;
                        col_next  = '0;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_STRING:
                begin
                    close_v = 1'b1;
                    if (byte_in == bst_pkg::CH_QUOTE)
                    begin
                        close_r   = bst_pkg::make_res(bst_pkg::KIND_STRING, '0, '0,
                                                      line_reg, tsc_reg, 1'b0);
                        mode_next = MODE_IDLE;
                    end
                    else if (byte_in == bst_pkg::CH_NEWLINE)
                    begin
                        close_r   = bst_pkg::make_res(bst_pkg::KIND_ERROR, '0, '0, line_reg,
                                                      tsc_reg, bst_pkg::ERR_NEWLINE_IN_STRING);
                        mode_next = MODE_ERROR;
                    end
                    else
                    begin
                        close_r = bst_pkg::make_res(bst_pkg::KIND_CHAR, byte_in, '0,
                                                    line_reg, col_inc, 1'b0);
                    end
                end
                MODE_NUMBER:
                begin
                    if (is_digit)
                    begin
                        acc_next = acc_sat;
                    end
                    else
                    begin
                        close_v = 1'b1;
                        close_r = bst_pkg::make_res(bst_pkg::KIND_NUMBER, '0, acc_reg,
                                                    line_reg, tsc_reg, 1'b0);
                        do_idle = 1'b1;
                    end
                end
                MODE_IDENT:
                begin
                    close_v = 1'b1;
                    if (is_letter || is_digit || (byte_in == bst_pkg::CH_UNDERSCORE))
                    begin
                        close_r = bst_pkg::make_res(bst_pkg::KIND_CHAR, byte_in, '0,
                                                    line_reg, col_inc, 1'b0);
                    end
                    else
                    begin
                        close_r = bst_pkg::make_res(bst_pkg::KIND_IDENT, '0, '0,
                                                    line_reg, tsc_reg, 1'b0);
                        do_idle = 1'b1;
                    end
                end
                default:
                    do_idle = 1'b1;
            endcase

            // Byte seen between tokens, including the one that ended a token.
            if (do_idle)
            begin
                mode_next = MODE_IDLE;
                if ((byte_in == bst_pkg::CH_SPACE) || (byte_in == bst_pkg::CH_TAB))
                begin
                    mode_next = MODE_IDLE;
                end
                else if (byte_in == bst_pkg::CH_NEWLINE)
                begin
                    line_next = line_inc;
                    col_next  = '0;
                end
                else if (byte_in == bst_pkg::CH_SLASH)
                begin
                    mode_next = MODE_SLASH;
                    tsc_next  = col_inc;
                end
                else if (byte_in == bst_pkg::CH_QUOTE)
                begin
                    mode_next = MODE_STRING;
                    tsc_next  = col_inc;
                end
                else if (is_digit)
                begin
                    mode_next = MODE_NUMBER;
                    tsc_next  = col_inc;
                    acc_next  = bst_pkg::NUM_W'(digit_val);
                end
                else if (is_letter)
                begin
                    mode_next = MODE_IDENT;
                    tsc_next  = col_inc;
                    sec_v     = 1'b1;
                    sec_r     = bst_pkg::make_res(bst_pkg::KIND_CHAR, byte_in, '0,
                                                  line_reg, col_inc, 1'b0);
                end
                else
                begin
                    sec_v = 1'b1;
                    sec_r = bst_pkg::make_res(bst_pkg::KIND_SYMBOL, byte_in, '0,
                                              line_reg, col_inc, 1'b0);
                end
            end
        end

        push.v0      = close_v || sec_v;
        push.v1      = close_v && sec_v;
        push.r0      = close_v ? close_r : sec_r;
        push.r1      = sec_r;
        push.r0.last = !push.v1;
        push.r1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            line_reg <= bst_pkg::CNT_W'(1);
            col_reg  <= '0;
            tsc_reg  <= '0;
            acc_reg  <= '0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            tsc_reg  <= tsc_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

@@ rtl/bst_out_stage.sv @@
module bst_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  bst_pkg::push_t   push,
    output logic             can_load,
    output logic             out_valid,
    input  logic             out_ready,
    output bst_pkg::result_t head
);

    logic             head_v_reg, head_v_next;
    logic             tail_v_reg, tail_v_next;
    bst_pkg::result_t head_reg, head_next;
    bst_pkg::result_t tail_reg, tail_next;
    logic             pop;

    assign pop       = head_v_reg && out_ready;
    // Both slots are free by the next edge.
    assign can_load  = !head_v_reg || (pop && !tail_v_reg);
    assign out_valid = head_v_reg;
    assign head      = head_reg;

    always_comb
    begin
        head_v_next = head_v_reg;
        tail_v_next = tail_v_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        if (load)
        begin
            head_v_next = push.v0;
            tail_v_next = push.v1;
            head_next   = push.r0;
            tail_next   = push.r1;
        end
        else if (pop)
        begin
            head_v_next = tail_v_reg;
            tail_v_next = 1'b0;
            head_next   = tail_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_v_reg <= 1'b0;
            tail_v_reg <= 1'b0;
        end
        else
        begin
            head_v_reg <= head_v_next;
            tail_v_reg <= tail_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

@@ rtl/byte_stream_tokenizer_unit.sv @@
// Streaming tokenizer: one source byte (or an end-of-file word) per input word, zero, one or
// two result words out. A word waits in the input register until the output stage registers
// its results. With out_ready high, one input word is taken every cycle as long as
// each word gives at most one result; a word that gives two results (a token closed by
// lookahead plus the next symbol or letter, or a token closed by end of file plus the end
// token) holds the input until the tail slot empties, as the two-slot output stage drains one
// result word per cycle. Identifier and string characters come out as they arrive, each token
// ends with one record that gives its kind, value or symbol and its start line and column.
module byte_stream_tokenizer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  char_code,
    output logic [30:0] number_value,
    output logic [15:0] line_number,
    output logic [15:0] column_number,
    output logic        error_code,
    output logic        last
);

    logic                        in_v_reg;
    logic [bst_pkg::CHAR_W-1:0]  byte_reg;
    logic                        eof_reg;
    logic                        can_load;
    logic                        fire;
    bst_pkg::push_t              push;
    bst_pkg::result_t            head;

    assign fire     = in_v_reg && can_load;
    assign in_ready = !in_v_reg || can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= byte_in;
            eof_reg  <= end_of_file;
        end
    end

    bst_lexer u_lexer (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .byte_in     (byte_reg),
        .end_of_file (eof_reg),
        .push        (push)
    );

    bst_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .push      (push),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign kind          = head.kind;
    assign char_code     = head.char_code;
    assign number_value  = head.number_value;
    assign line_number   = head.line_number;
    assign column_number = head.column_number;
    assign error_code    = head.error_code;
    assign last          = head.last;

endmodule

@@ rtl/bst_checker.sv @@
module bst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  byte_in,
    input logic        end_of_file,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  kind,
    input logic [7:0]  char_code,
    input logic [30:0] number_value,
    input logic [15:0] line_number,
    input logic [15:0] column_number,
    input logic        error_code,
    input logic        last
);

    // A stalled result word keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(char_code)
            && $stable(number_value) && $stable(last))
        else $error("result word changed while stalled");

    // The end token is always the final result of its input word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == bst_pkg::KIND_END) |-> last)
        else $error("end token without last");

    // Only lexeme characters and symbols carry a character code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != bst_pkg::KIND_CHAR) && (kind != bst_pkg::KIND_SYMBOL)
            |-> (char_code == 8'd0))
        else $error("character code on a non-character result");

    // Only number tokens carry a value, and lines start at one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (line_number != 16'd0)
            && ((kind == bst_pkg::KIND_NUMBER) || (number_value == 31'd0)))
        else $error("bad line number or stray number value");

endmodule

bind byte_stream_tokenizer_unit bst_checker u_bst_checker (.*);

@@ tb/tb_byte_stream_tokenizer_unit.sv @@
`timescale 1ns / 1ps

module tb_byte_stream_tokenizer_unit;

    localparam int unsigned CYCLE_LIMIT = 600000;

    typedef enum logic [2:0] {
        LX_IDLE,
        LX_SLASH,
        LX_COMMENT,
        LX_STRING,
        LX_NUMBER,
        LX_IDENT,
        LX_ERROR
    } lexer_mode_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [7:0]  byte_in     = '0;
    logic        end_of_file = 1'b0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  char_code;
    logic [30:0] number_value;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        error_code;
    logic        last;

    // Tokenizer state as the testbench tracks it.
    lexer_mode_t               lx_mode  = LX_IDLE;
    logic [bst_pkg::CNT_W-1:0] cur_line = 16'd1;
    logic [bst_pkg::CNT_W-1:0] cur_col  = '0;
    logic [bst_pkg::CNT_W-1:0] tok_col  = '0;
    logic [bst_pkg::NUM_W-1:0] num_acc  = '0;

    bst_pkg::result_t pending_tokens[$];
    int               errors       = 0;
    int               useful_words = 0;
    int               in_calm      = 0;
    int               out_calm     = 0;
    int unsigned      cycle_count  = 0;

    byte_stream_tokenizer_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .byte_in       (byte_in),
        .end_of_file   (end_of_file),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .char_code     (char_code),
        .number_value  (number_value),
        .line_number   (line_number),
        .column_number (column_number),
        .error_code    (error_code),
        .last          (last)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic bit is_digit(input logic [7:0] c);
        return c >= bst_pkg::CH_ZERO && c <= bst_pkg::CH_NINE;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= bst_pkg::CH_UPPER_A && c <= bst_pkg::CH_UPPER_Z)
            || (c >= bst_pkg::CH_LOWER_A && c <= bst_pkg::CH_LOWER_Z);
    endfunction

    function automatic logic [bst_pkg::CNT_W-1:0] bump(input logic [bst_pkg::CNT_W-1:0] v);
        return (v == bst_pkg::CNT_MAX) ? v : v + 16'd1;
    endfunction

    // Mostly random waits, with occasional stretches of back-to-back words.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm_left = $urandom_range(8, 40);
        return $urandom_range(0, 15);
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) == 1)
            return bst_pkg::CH_UPPER_A + 8'($urandom_range(0, 25));
        return bst_pkg::CH_LOWER_A + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_ident_tail();
        case ($urandom_range(0, 3))
            0: return bst_pkg::CH_ZERO + 8'($urandom_range(0, 9));
            1: return bst_pkg::CH_UNDERSCORE;
            default: return rand_letter();
        endcase
    endfunction

    function automatic logic [7:0] rand_symbol();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_digit(c) || is_letter(c) || c == bst_pkg::CH_SPACE || c == bst_pkg::CH_TAB
               || c == bst_pkg::CH_NEWLINE || c == bst_pkg::CH_SLASH
               || c == bst_pkg::CH_QUOTE);
        return c;
    endfunction

    function automatic logic [7:0] rand_string_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == bst_pkg::CH_QUOTE || c == bst_pkg::CH_NEWLINE);
        return c;
    endfunction

    function automatic void push_token(input logic [bst_pkg::KIND_W-1:0] k,
                                       input logic [7:0] ch,
                                       input logic [bst_pkg::NUM_W-1:0] num,
                                       input logic [bst_pkg::CNT_W-1:0] ln,
                                       input logic [bst_pkg::CNT_W-1:0] col, input logic err);
        bst_pkg::result_t r;
        r.kind          = k;
        r.char_code     = ch;
        r.number_value  = num;
        r.line_number   = ln;
        r.column_number = col;
        r.error_code    = err;
        r.last          = 1'b0;
        pending_tokens.push_back(r);
    endfunction

    // A byte seen between tokens; its column has already been counted.
    function automatic void open_token(input logic [7:0] c);
        if (c == bst_pkg::CH_SPACE || c == bst_pkg::CH_TAB)
        begin
        end
        else if (c == bst_pkg::CH_NEWLINE)
        begin
            cur_line = bump(cur_line);
            cur_col  = '0;
        end
        else if (c == bst_pkg::CH_SLASH)
        begin
            lx_mode = LX_SLASH;
            tok_col = cur_col;
        end
        else if (c == bst_pkg::CH_QUOTE)
        begin
            lx_mode = LX_STRING;
            tok_col = cur_col;
        end
        else if (is_digit(c))
        begin
            lx_mode = LX_NUMBER;
            tok_col = cur_col;
            num_acc = bst_pkg::NUM_W'(c - bst_pkg::CH_ZERO);
        end
        else if (is_letter(c))
        begin
            lx_mode = LX_IDENT;
            tok_col = cur_col;
            push_token(bst_pkg::KIND_CHAR, c, '0, cur_line, cur_col, 1'b0);
        end
        else
            push_token(bst_pkg::KIND_SYMBOL, c, '0, cur_line, cur_col, 1'b0);
    endfunction

    function automatic void tokenize_word(input logic [7:0] c, input logic eof);
        int               first_new;
        logic [34:0]      scaled;
        bst_pkg::result_t tail;
        first_new = pending_tokens.size();
        if (eof)
        begin
            useful_words++;
            case (lx_mode)
                LX_SLASH:  push_token(bst_pkg::KIND_SYMBOL, bst_pkg::CH_SLASH, '0, cur_line,
                                      tok_col, 1'b0);
                LX_NUMBER: push_token(bst_pkg::KIND_NUMBER, '0, num_acc, cur_line, tok_col,
                                      1'b0);
                LX_IDENT:  push_token(bst_pkg::KIND_IDENT, '0, '0, cur_line, tok_col, 1'b0);
                LX_STRING: push_token(bst_pkg::KIND_ERROR, '0, '0, cur_line, tok_col,
                                      bst_pkg::ERR_EOF_IN_STRING);
                default:   ;
            endcase
            push_token(bst_pkg::KIND_END, '0, '0, cur_line, bump(cur_col), 1'b0);
            lx_mode  = LX_IDLE;
            cur_line = 16'd1;
            cur_col  = '0;
            tok_col  = '0;
            num_acc  = '0;
        end
        else if (lx_mode != LX_ERROR)
        begin
            useful_words++;
            cur_col = bump(cur_col);
            case (lx_mode)
                LX_SLASH:
                    if (c == bst_pkg::CH_SLASH)
                        lx_mode = LX_COMMENT;
                    else
                    begin
                        push_token(bst_pkg::KIND_SYMBOL, bst_pkg::CH_SLASH, '0, cur_line,
                                   tok_col, 1'b0);
                        lx_mode = LX_IDLE;
                        open_token(c);
                    end
                LX_COMMENT:
                    if (c == bst_pkg::CH_NEWLINE)
                    begin
                        cur_line = bump(cur_line);
                        cur_col  = '0;
                        lx_mode  = LX_IDLE;
                    end
                LX_STRING:
                    if (c == bst_pkg::CH_QUOTE)
                    begin
                        push_token(bst_pkg::KIND_STRING, '0, '0, cur_line, tok_col, 1'b0);
                        lx_mode = LX_IDLE;
                    end
                    else if (c == bst_pkg::CH_NEWLINE)
                    begin
                        push_token(bst_pkg::KIND_ERROR, '0, '0, cur_line, tok_col,
                                   bst_pkg::ERR_NEWLINE_IN_STRING);
                        lx_mode = LX_ERROR;
                    end
                    else
                        push_token(bst_pkg::KIND_CHAR, c, '0, cur_line, cur_col, 1'b0);
                LX_NUMBER:
                    if (is_digit(c))
                    begin
                        scaled  = {4'b0, num_acc} * 35'd10 + {27'b0, c - bst_pkg::CH_ZERO};
                        num_acc = (scaled > {4'b0, bst_pkg::NUM_MAX}) ? bst_pkg::NUM_MAX
                                                                       : scaled[30:0];
                    end
                    else
                    begin
                        push_token(bst_pkg::KIND_NUMBER, '0, num_acc, cur_line, tok_col, 1'b0);
                        lx_mode = LX_IDLE;
                        open_token(c);
                    end
                LX_IDENT:
                    if (is_letter(c) || is_digit(c) || c == bst_pkg::CH_UNDERSCORE)
                        push_token(bst_pkg::KIND_CHAR, c, '0, cur_line, cur_col, 1'b0);
                    else
                    begin
                        push_token(bst_pkg::KIND_IDENT, '0, '0, cur_line, tok_col, 1'b0);
                        lx_mode = LX_IDLE;
                        open_token(c);
                    end
                default:
                begin
                    lx_mode = LX_IDLE;
                    open_token(c);
                end
            endcase
        end
        if (pending_tokens.size() > first_new)
        begin
            tail      = pending_tokens.pop_back();
            tail.last = 1'b1;
            pending_tokens.push_back(tail);
        end
    endfunction

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic feed_word(input logic [7:0] b, input logic eof);
        int gap;
        gap = draw_wait(in_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        byte_in     <= b;
        end_of_file <= eof;
        do
            @(posedge clk);
        while (!in_ready);
        tokenize_word(b, eof);
    endtask

    task automatic close_file();
        feed_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    initial
    begin : token_sink
        bst_pkg::result_t want;
        int               stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_wait(out_calm);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if (pending_tokens.size() == 0)
            begin
                errors++;
                $display("%0t: result expected none actual kind %0d char %0d", $time,
                         kind, char_code);
            end
            else
            begin
                want = pending_tokens.pop_front();
                check_field("kind", want.kind, kind);
                check_field("char_code", want.char_code, char_code);
                check_field("number_value", want.number_value, number_value);
                check_field("line_number", want.line_number, line_number);
                check_field("column_number", want.column_number, column_number);
                check_field("error_code", want.error_code, error_code);
                check_field("last", want.last, last);
            end
        end
    end

    // Control bytes, high bytes and underscore are symbols; a lone slash closes on the
    // next byte, which here starts an identifier, so that word gives two results.
    task automatic test_symbols_and_extremes();
        feed_word(8'h00, 1'b0);
        feed_word(8'hFF, 1'b0);
        feed_word(bst_pkg::CH_UNDERSCORE, 1'b0);
        feed_word(bst_pkg::CH_SLASH, 1'b0);
        feed_word("x", 1'b0);
        close_file();
    endtask

    task automatic test_numbers_and_comments();
        feed_word("9", 1'b0);
        feed_word(bst_pkg::CH_SLASH, 1'b0);
        feed_word(bst_pkg::CH_SLASH, 1'b0);
        feed_word("q", 1'b0);
        feed_word(bst_pkg::CH_NEWLINE, 1'b0);
        feed_word("5", 1'b0);
        feed_word(bst_pkg::CH_SLASH, 1'b0);
        close_file();
        // End of file inside a comment closes silently.
        feed_word(bst_pkg::CH_SLASH, 1'b0);
        feed_word(bst_pkg::CH_SLASH, 1'b0);
        close_file();
    endtask

    task automatic test_strings();
        feed_word(bst_pkg::CH_QUOTE, 1'b0);
        feed_word("A", 1'b0);
        feed_word(bst_pkg::CH_QUOTE, 1'b0);
        feed_word(bst_pkg::CH_QUOTE, 1'b0);
        feed_word(bst_pkg::CH_NEWLINE, 1'b0);
        feed_word("z", 1'b0);
        close_file();
        feed_word(bst_pkg::CH_QUOTE, 1'b0);
        close_file();
    endtask

    task automatic test_random_source();
        int goal;
        int pick;
        int len;
        goal = useful_words + 400;
        while (useful_words < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 18)
            begin
                feed_word(rand_letter(), 1'b0);
                len = $urandom_range(0, 7);
                repeat (len) feed_word(rand_ident_tail(), 1'b0);
            end
            else if (pick < 33)
            begin
                // Eleven or more digits saturate a number unless leading zeros keep it in range.
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 4);
                repeat (len) feed_word(bst_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
            end
            else if (pick < 45)
            begin
                feed_word(bst_pkg::CH_QUOTE, 1'b0);
                len = $urandom_range(0, 6);
                repeat (len) feed_word(rand_string_byte(), 1'b0);
                feed_word(bst_pkg::CH_QUOTE, 1'b0);
            end
            else if (pick < 60)
            begin
                case ($urandom_range(0, 2))
                    0: feed_word(bst_pkg::CH_SPACE, 1'b0);
                    1: feed_word(bst_pkg::CH_TAB, 1'b0);
                    default: feed_word(bst_pkg::CH_NEWLINE, 1'b0);
                endcase
            end
            else if (pick < 68)
            begin
                feed_word(bst_pkg::CH_SLASH, 1'b0);
                feed_word(bst_pkg::CH_SLASH, 1'b0);
                len = $urandom_range(0, 6);
                repeat (len) feed_word(rand_string_byte(), 1'b0);
                feed_word(bst_pkg::CH_NEWLINE, 1'b0);
            end
            else if (pick < 74)
                feed_word(rand_symbol(), 1'b0);
            else if (pick < 78)
                feed_word(bst_pkg::CH_SLASH, 1'b0);
            else if (pick < 86)
                feed_word(8'($urandom_range(0, 255)), 1'b0);
            else if (pick < 89)
            begin
                // A string broken by a newline; what follows is dropped until end of file.
                feed_word(bst_pkg::CH_QUOTE, 1'b0);
                len = $urandom_range(0, 3);
                repeat (len) feed_word(rand_string_byte(), 1'b0);
                feed_word(bst_pkg::CH_NEWLINE, 1'b0);
                len = $urandom_range(0, 4);
                repeat (len) feed_word(8'($urandom_range(0, 255)), 1'b0);
                close_file();
            end
            else if (pick < 92)
                close_file();
            else
                feed_word(rand_ident_tail(), 1'b0);
        end
        close_file();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_symbols_and_extremes();
        test_numbers_and_comments();
        test_strings();
        test_random_source();
        in_valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/bst_pkg.sv
rtl/bst_lexer.sv
rtl/bst_out_stage.sv
rtl/byte_stream_tokenizer_unit.sv
rtl/bst_checker.sv
tb/tb_byte_stream_tokenizer_unit.sv
